### rtl/pbnc_pkg.sv
// ----------------------------------------------------------------------------
// pbnc_pkg
// Shared types and constants of the palette blend and nearest colour block.
// ----------------------------------------------------------------------------
package pbnc_pkg;

	localparam int CH_W   = 8;
	localparam int IDX_W  = 8;
	localparam int WGT_W  = 16;
	localparam int SQ_W   = 2 * CH_W;
	localparam int PROD_W = SQ_W + WGT_W;
	localparam int DIST_W = PROD_W + 2;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef enum logic [3:0] {
		BM_ADDSAT  = 4'd0,
		BM_SUBSAT  = 4'd1,
		BM_AND     = 4'd2,
		BM_OR      = 4'd3,
		BM_XOR     = 4'd4,
		BM_ABSDIFF = 4'd5,
		BM_MAX     = 4'd6,
		BM_MIN     = 4'd7,
		BM_FADEOUT = 4'd8,
		BM_FADEIN  = 4'd9,
		BM_INC     = 4'd10,
		BM_DEC     = 4'd11
	} blend_mode_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_BLEND = 2'd1,
		OP_QUANT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_MIX,
		ST_SCAN,
		ST_WAIT
	} state_t;

	localparam logic [1:0] REG_BLEND_MODE   = 2'd0;
	localparam logic [1:0] REG_WEIGHT_RED   = 2'd1;
	localparam logic [1:0] REG_WEIGHT_GREEN = 2'd2;
	localparam logic [1:0] REG_WEIGHT_BLUE  = 2'd3;

	localparam logic [WGT_W-1:0] WEIGHT_RED_RST   = 16'd19461;
	localparam logic [WGT_W-1:0] WEIGHT_GREEN_RST = 16'd38444;
	localparam logic [WGT_W-1:0] WEIGHT_BLUE_RST  = 16'd7500;

	// tag that travels with each palette read through the distance pipe
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] index;
	} scan_tag_t;

endpackage

### rtl/palette_blend_nearest_colour.sv
// ----------------------------------------------------------------------------
// palette_blend_nearest_colour
// A palette write is taken only while idle. A quantize query scans the palette;
// a blend first reads colours A and B, mixes them and then scans for the mix.
// The scan reads one entry per cycle, done rises once the last entry has passed
// the distance pipe, and busy falls in the cycle after done: one query at a time.
// done is a one-cycle strobe, the receiver cannot stall the block.
// Reset clears control and loads the register reset values; palette undefined.
// ----------------------------------------------------------------------------
module palette_blend_nearest_colour
	import pbnc_pkg::*;
#(
	parameter int PALETTE_SIZE = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [CH_W-1:0]   red,
	input  logic [CH_W-1:0]   green,
	input  logic [CH_W-1:0]   blue,
	input  logic [IDX_W-1:0]  colour_a,
	input  logic [IDX_W-1:0]  colour_b,
	input  logic [CH_W-1:0]   amount,
	output logic              done,
	output logic [IDX_W-1:0]  nearest_index,
	output logic [CH_W-1:0]   mixed_red,
	output logic [CH_W-1:0]   mixed_green,
	output logic [CH_W-1:0]   mixed_blue,
	output logic [DIST_W-1:0] best_distance,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [WGT_W-1:0]  cfg_data
);

	localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam logic [IDX_W:0] PAL_LIMIT = (IDX_W+1)'(PALETTE_SIZE);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(PALETTE_SIZE - 1);

	state_t            state_q, state_d;
	blend_mode_t       mode_q;
	logic [WGT_W-1:0]  weight_red_q, weight_green_q, weight_blue_q;
	logic [IDX_W-1:0]  a_q, b_q;
	logic              a_oob_q, b_oob_q;
	logic [CH_W-1:0]   amount_q;
	rgb_t              col_a_q, query_q;
	logic [AW-1:0]     scan_q;
	scan_tag_t         rd_tag_q, rd_tag_d;
	logic              accept;
	logic              we;
	logic [AW-1:0]     raddr;
	rgb_t              rdata, rdata_b, mixed;
	logic              scan_clr, scan_inc;
	logic              cap_a, cap_mix;
	op_t               op_in;

	assign accept    = start && !busy;
	assign op_in     = op_t'(op);
	assign cfg_ready = 1'b1;
	assign we        = accept && op_in == OP_WRITE && {1'b0, entry_index} < PAL_LIMIT;
	assign rdata_b   = b_oob_q ? '0 : rdata;

	pbnc_palette #(
		.DEPTH(PALETTE_SIZE),
		.AW   (AW)
	) u_palette (
		.clk  (clk),
		.we   (we),
		.waddr(entry_index[AW-1:0]),
		.wdata('{r: red, g: green, b: blue}),
		.raddr(raddr),
		.rdata(rdata)
	);

	pbnc_blend u_blend (
		.mode  (mode_q),
		.col_a (col_a_q),
		.col_b (rdata_b),
		.amount(amount_q),
		.mixed (mixed)
	);

	pbnc_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag         (rd_tag_q),
		.pal         (rdata),
		.query       (query_q),
		.weight_red  (weight_red_q),
		.weight_green(weight_green_q),
		.weight_blue (weight_blue_q),
		.done        (done),
		.best_index  (nearest_index),
		.best_dist   (best_distance)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= BM_ADDSAT;
			weight_red_q   <= WEIGHT_RED_RST;
			weight_green_q <= WEIGHT_GREEN_RST;
			weight_blue_q  <= WEIGHT_BLUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLEND_MODE:   mode_q         <= blend_mode_t'(cfg_data[3:0]);
				REG_WEIGHT_RED:   weight_red_q   <= cfg_data;
				REG_WEIGHT_GREEN: weight_green_q <= cfg_data;
				REG_WEIGHT_BLUE:  weight_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scan_q   <= '0;
			rd_tag_q <= '0;
		end else begin
			state_q  <= state_d;
			rd_tag_q <= rd_tag_d;
			if (scan_clr) begin
				scan_q <= '0;
			end else if (scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q      <= colour_a;
			b_q      <= colour_b;
			a_oob_q  <= {1'b0, colour_a} >= PAL_LIMIT;
			b_oob_q  <= {1'b0, colour_b} >= PAL_LIMIT;
			amount_q <= amount;
		end
		if (accept && op_in == OP_QUANT) begin
			query_q <= '{r: red, g: green, b: blue};
		end else if (cap_mix) begin
			query_q <= mixed;
		end
		if (cap_a) begin
			col_a_q <= a_oob_q ? '0 : rdata;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		raddr    = scan_q;
		scan_clr = 1'b0;
		scan_inc = 1'b0;
		cap_a    = 1'b0;
		cap_mix  = 1'b0;
		rd_tag_d = '0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				scan_clr = 1'b1;
				if (start) begin
					case (op_in)
						OP_BLEND: state_d = ST_RD_A;
						OP_QUANT: state_d = ST_SCAN;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_A: begin
				raddr   = a_q[AW-1:0];
				state_d = ST_RD_B;
			end
			ST_RD_B: begin
				raddr   = b_q[AW-1:0];
				cap_a   = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cap_mix = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				scan_inc       = 1'b1;
				rd_tag_d.valid = 1'b1;
				rd_tag_d.last  = scan_q == LAST_ADDR;
				rd_tag_d.index = IDX_W'(scan_q);
				if (scan_q == LAST_ADDR) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign mixed_red   = query_q.r;
	assign mixed_green = query_q.g;
	assign mixed_blue  = query_q.b;

endmodule

### rtl/pbnc_palette.sv
// ----------------------------------------------------------------------------
// pbnc_palette
// Palette RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pbnc_palette
	import pbnc_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rgb_t          wdata,
	input  logic [AW-1:0] raddr,
	output rgb_t          rdata
);

	rgb_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/pbnc_blend.sv
// ----------------------------------------------------------------------------
// pbnc_blend
// Per-channel colour blend of two palette colours in the configured mode.
// ----------------------------------------------------------------------------
module pbnc_blend
	import pbnc_pkg::*;
(
	input  blend_mode_t     mode,
	input  rgb_t            col_a,
	input  rgb_t            col_b,
	input  logic [CH_W-1:0] amount,
	output rgb_t            mixed
);

	function automatic logic [CH_W-1:0] mix_chan(input blend_mode_t m,
		input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
		input logic [CH_W-1:0] o);
		logic [CH_W:0]   sum;
		logic [CH_W-1:0] off;
		logic [CH_W-1:0] fade;
		logic [CH_W-1:0] res;
		sum = {1'b0, a} + {1'b0, b};
		off = (m == BM_FADEIN) ? ~o : o;
		fade = (a > off) ? a - off : '0;
		case (m)
			BM_ADDSAT:  res = sum[CH_W] ? '1 : sum[CH_W-1:0];
			BM_SUBSAT:  res = (a > b) ? a - b : '0;
			BM_AND:     res = a & b;
			BM_OR:      res = a | b;
			BM_XOR:     res = a ^ b;
			BM_ABSDIFF: res = (a > b) ? a - b : b - a;
			BM_MAX:     res = (a > b) ? a : b;
			BM_MIN:     res = (a < b) ? a : b;
			BM_FADEOUT: res = (fade > b) ? fade : b;
			BM_FADEIN:  res = (fade > b) ? fade : b;
			BM_INC:     res = (a == '1) ? a : a + 1'b1;
			BM_DEC:     res = (a == '0) ? a : a - 1'b1;
			default:    res = a;
		endcase
		return res;
	endfunction

	always_comb begin
		mixed.r = mix_chan(mode, col_a.r, col_b.r, amount);
		mixed.g = mix_chan(mode, col_a.g, col_b.g, amount);
		mixed.b = mix_chan(mode, col_a.b, col_b.b, amount);
	end

endmodule

### rtl/pbnc_dist.sv
// ----------------------------------------------------------------------------
// pbnc_dist
// Pipelined weighted squared distance unit with running minimum search.
// ----------------------------------------------------------------------------
module pbnc_dist
	import pbnc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  scan_tag_t          tag,
	input  rgb_t               pal,
	input  rgb_t               query,
	input  logic [WGT_W-1:0]   weight_red,
	input  logic [WGT_W-1:0]   weight_green,
	input  logic [WGT_W-1:0]   weight_blue,
	output logic               done,
	output logic [IDX_W-1:0]   best_index,
	output logic [DIST_W-1:0]  best_dist
);

	scan_tag_t         tag_s1, tag_s2, tag_s3, tag_s4;
	logic [CH_W-1:0]   dr_s1, dg_s1, db_s1;
	logic [SQ_W-1:0]   sr_s2, sg_s2, sb_s2;
	logic [PROD_W-1:0] pr_s3, pg_s3, pb_s3;
	logic [DIST_W-1:0] sum_s4;
	logic [IDX_W-1:0]  best_index_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              done_q;

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] x,
		input logic [CH_W-1:0] y);
		return (x > y) ? x - y : y - x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			done_q <= tag_s4.valid && tag_s4.last;
		end
	end

	always_ff @(posedge clk) begin
		dr_s1  <= abs_diff(pal.r, query.r);
		dg_s1  <= abs_diff(pal.g, query.g);
		db_s1  <= abs_diff(pal.b, query.b);
		sr_s2  <= SQ_W'(dr_s1) * SQ_W'(dr_s1);
		sg_s2  <= SQ_W'(dg_s1) * SQ_W'(dg_s1);
		sb_s2  <= SQ_W'(db_s1) * SQ_W'(db_s1);
		pr_s3  <= PROD_W'(sr_s2) * PROD_W'(weight_red);
		pg_s3  <= PROD_W'(sg_s2) * PROD_W'(weight_green);
		pb_s3  <= PROD_W'(sb_s2) * PROD_W'(weight_blue);
		sum_s4 <= DIST_W'(pr_s3) + DIST_W'(pg_s3) + DIST_W'(pb_s3);
	end

	// first entry always taken, later ones only when strictly closer
	always_ff @(posedge clk) begin
		if (tag_s4.valid && (tag_s4.index == '0 || sum_s4 < best_dist_q)) begin
			best_dist_q  <= sum_s4;
			best_index_q <= tag_s4.index;
		end
	end

	assign done       = done_q;
	assign best_index = best_index_q;
	assign best_dist  = best_dist_q;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for palette_blend_nearest_colour. The palette is loaded
// first. Then directed and random write, blend and quantize words run against
// a predictor inside the bench. Blend mode and weights change between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import pbnc_pkg::*;

	localparam int PAL_ENTRIES   = 256;
	localparam int SETTLE_CYCLES = PAL_ENTRIES + 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int BLOCKS        = 12;
	localparam int BLOCK_ITEMS   = 18;

	localparam logic [1:0]       OP_NONE   = 2'd3;
	localparam logic [3:0]       MODE_LAST = 4'd15;
	localparam logic [WGT_W-1:0] WEIGHT_MAX = '1;

	localparam int BLACK_IDX = 0;
	localparam int WHITE_IDX = 255;
	localparam int MIX_A     = 4;
	localparam int MIX_B     = 5;
	localparam int TIE_LO    = 7;
	localparam int TIE_HI    = 200;

	localparam rgb_t MIX_A_COLOUR = 24'h8040c0;
	localparam rgb_t MIX_B_COLOUR = 24'h3ca55a;
	localparam rgb_t TIE_COLOUR   = 24'h102030;

	typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [6:0]       gap_pct;
		logic [1:0]       op;
		logic [IDX_W-1:0] entry_index;
		rgb_t             pix;
		logic [IDX_W-1:0] colour_a;
		logic [IDX_W-1:0] colour_b;
		logic [CH_W-1:0]  amount;
		logic [1:0]       reg_index;
		logic [WGT_W-1:0] reg_data;
	} job_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		rgb_t              colour;
		logic [DIST_W-1:0] distance;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        op = OP_WRITE;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [CH_W-1:0]   red = '0;
	logic [CH_W-1:0]   green = '0;
	logic [CH_W-1:0]   blue = '0;
	logic [IDX_W-1:0]  colour_a = '0;
	logic [IDX_W-1:0]  colour_b = '0;
	logic [CH_W-1:0]   amount = '0;
	logic              done;
	logic [IDX_W-1:0]  nearest_index;
	logic [CH_W-1:0]   mixed_red;
	logic [CH_W-1:0]   mixed_green;
	logic [CH_W-1:0]   mixed_blue;
	logic [DIST_W-1:0] best_distance;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = REG_BLEND_MODE;
	logic [WGT_W-1:0]  cfg_data = '0;

	job_t    pending_jobs[$];
	result_t due_results[$];

	rgb_t             pal_model [PAL_ENTRIES];
	logic [3:0]       mode_model;
	logic [WGT_W-1:0] wr_model;
	logic [WGT_W-1:0] wg_model;
	logic [WGT_W-1:0] wb_model;

	int          fill_gap = 0;
	int          quiet_cycles = 0;
	int          cycle_count = 0;
	int          fail_count = 0;
	int          n_writes = 0;
	int          n_blends = 0;
	int          n_quants = 0;
	int          n_regs = 0;
	int          n_checked = 0;
	logic [15:0] modes_seen = '0;

	palette_blend_nearest_colour #(
		.PALETTE_SIZE(PAL_ENTRIES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.colour_a     (colour_a),
		.colour_b     (colour_b),
		.amount       (amount),
		.done         (done),
		.nearest_index(nearest_index),
		.mixed_red    (mixed_red),
		.mixed_green  (mixed_green),
		.mixed_blue   (mixed_blue),
		.best_distance(best_distance),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [CH_W-1:0] mix_channel(logic [3:0] m, logic [CH_W-1:0] a,
			logic [CH_W-1:0] b, logic [CH_W-1:0] o);
		logic [CH_W:0]   sum;
		logic [CH_W-1:0] off;
		logic [CH_W-1:0] cut;
		sum = {1'b0, a} + {1'b0, b};
		off = ~o;
		case (m)
			BM_ADDSAT:  return sum[CH_W] ? '1 : sum[CH_W-1:0];
			BM_SUBSAT:  return a > b ? a - b : '0;
			BM_AND:     return a & b;
			BM_OR:      return a | b;
			BM_XOR:     return a ^ b;
			BM_ABSDIFF: return a > b ? a - b : b - a;
			BM_MAX:     return a > b ? a : b;
			BM_MIN:     return a < b ? a : b;
			BM_FADEOUT: begin
				cut = a > o ? a - o : '0;
				return cut > b ? cut : b;
			end
			BM_FADEIN: begin
				cut = a > off ? a - off : '0;
				return cut > b ? cut : b;
			end
			BM_INC:     return a == '1 ? a : a + 1'b1;
			BM_DEC:     return a == '0 ? a : a - 1'b1;
			default:    return a;
		endcase
	endfunction

	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic job_t random_item(logic [1:0] o);
		job_t j;
		j = '0;
		j.kind = JOB_ITEM;
		j.gap_pct = 7'(fill_gap);
		j.op = o;
		j.entry_index = IDX_W'($urandom);
		j.pix = {pick_channel(), pick_channel(), pick_channel()};
		j.colour_a = IDX_W'($urandom);
		j.colour_b = IDX_W'($urandom);
		j.amount = pick_channel();
		return j;
	endfunction

	function automatic void add_job(job_t j);
		pending_jobs.insert(pending_jobs.size(), j);
	endfunction

	function automatic void queue_cfg(logic [1:0] idx, logic [WGT_W-1:0] v);
		job_t j;
		j = '0;
		j.kind = JOB_CFG;
		j.reg_index = idx;
		j.reg_data = v;
		add_job(j);
	endfunction

	function automatic void queue_drain();
		job_t j;
		j = '0;
		j.kind = JOB_DRAIN;
		add_job(j);
	endfunction

	always @(posedge clk) begin : driver
		job_t              j;
		rgb_t              ca;
		rgb_t              cb;
		rgb_t              q;
		result_t           res;
		logic [CH_W-1:0]   dr;
		logic [CH_W-1:0]   dg;
		logic [CH_W-1:0]   db;
		logic [DIST_W-1:0] d;
		logic              nxt_start;
		logic              nxt_cfg;
		if (!arst_n) begin
			mode_model = BM_ADDSAT;
			wr_model = WEIGHT_RED_RST;
			wg_model = WEIGHT_GREEN_RST;
			wb_model = WEIGHT_BLUE_RST;
			start <= 1'b0;
			cfg_valid <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;
			if (start && !busy) begin
				nxt_start = 1'b0;
				case (op)
					OP_WRITE: begin
						pal_model[entry_index] = {red, green, blue};
						n_writes++;
					end
					OP_BLEND, OP_QUANT: begin
						if (op == OP_BLEND) begin
							ca = pal_model[colour_a];
							cb = pal_model[colour_b];
							q.r = mix_channel(mode_model, ca.r, cb.r, amount);
							q.g = mix_channel(mode_model, ca.g, cb.g, amount);
							q.b = mix_channel(mode_model, ca.b, cb.b, amount);
							modes_seen[mode_model] = 1'b1;
							n_blends++;
						end else begin
							q = {red, green, blue};
							n_quants++;
						end
						res.colour = q;
						res.index = '0;
						res.distance = '0;
						// first entry always taken, later ones only when strictly closer
						for (int i = 0; i < PAL_ENTRIES; i++) begin
							dr = pal_model[i].r > q.r ? pal_model[i].r - q.r : q.r - pal_model[i].r;
							dg = pal_model[i].g > q.g ? pal_model[i].g - q.g : q.g - pal_model[i].g;
							db = pal_model[i].b > q.b ? pal_model[i].b - q.b : q.b - pal_model[i].b;
							d = dr * dr * wr_model + dg * dg * wg_model + db * db * wb_model;
							if (i == 0 || d < res.distance) begin
								res.distance = d;
								res.index = IDX_W'(i);
							end
						end
						due_results.insert(due_results.size(), res);
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				nxt_cfg = 1'b0;
				n_regs++;
				case (cfg_index)
					REG_BLEND_MODE:   mode_model = cfg_data[3:0];
					REG_WEIGHT_RED:   wr_model = cfg_data;
					REG_WEIGHT_GREEN: wg_model = cfg_data;
					REG_WEIGHT_BLUE:  wb_model = cfg_data;
					default: ;
				endcase
			end
			if (!nxt_start && !nxt_cfg && pending_jobs.size() != 0) begin
				j = pending_jobs[0];
				case (j.kind)
					JOB_ITEM: begin
						if ($urandom_range(99) >= j.gap_pct) begin
							pending_jobs.delete(0);
							nxt_start = 1'b1;
							op <= j.op;
							entry_index <= j.entry_index;
							red <= j.pix.r;
							green <= j.pix.g;
							blue <= j.pix.b;
							colour_a <= j.colour_a;
							colour_b <= j.colour_b;
							amount <= j.amount;
						end
					end
					JOB_CFG: begin
						if (quiet_cycles >= SETTLE_CYCLES) begin
							pending_jobs.delete(0);
							nxt_cfg = 1'b1;
							cfg_index <= j.reg_index;
							cfg_data <= j.reg_data;
						end
					end
					default: begin
						if (due_results.size() == 0)
							pending_jobs.delete(0);
					end
				endcase
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
			if (nxt_start || busy || due_results.size() != 0)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && done) begin
			n_checked++;
			if (due_results.size() == 0) begin
				$error("result with nothing expected: nearest_index %0d", nearest_index);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (nearest_index !== want.index) begin
					$error("nearest_index mismatch: expected %0d, got %0d", want.index, nearest_index);
					fail_count++;
				end
				if (mixed_red !== want.colour.r) begin
					$error("mixed_red mismatch: expected %0d, got %0d", want.colour.r, mixed_red);
					fail_count++;
				end
				if (mixed_green !== want.colour.g) begin
					$error("mixed_green mismatch: expected %0d, got %0d", want.colour.g, mixed_green);
					fail_count++;
				end
				if (mixed_blue !== want.colour.b) begin
					$error("mixed_blue mismatch: expected %0d, got %0d", want.colour.b, mixed_blue);
					fail_count++;
				end
				if (best_distance !== want.distance) begin
					$error("best_distance mismatch: expected %0d, got %0d", want.distance,
						best_distance);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		job_t             j;
		int               r;
		logic [WGT_W-1:0] mode_word;
		logic [WGT_W-1:0] w_red;
		logic [WGT_W-1:0] w_green;
		logic [WGT_W-1:0] w_blue;

		// palette load, every entry written before any query
		fill_gap = 23;
		for (int i = 0; i < PAL_ENTRIES; i++) begin
			j = random_item(OP_WRITE);
			j.entry_index = IDX_W'(i);
			if (i == BLACK_IDX)
				j.pix = '0;
			else if (i == WHITE_IDX)
				j.pix = '1;
			else if (i == TIE_LO || i == TIE_HI)
				j.pix = TIE_COLOUR;
			else if (i == MIX_A)
				j.pix = MIX_A_COLOUR;
			else if (i == MIX_B)
				j.pix = MIX_B_COLOUR;
			add_job(j);
		end

		// directed queries under reset register values
		j = random_item(OP_QUANT);
		j.pix = '0;
		add_job(j);
		j.pix = '1;
		add_job(j);
		j.pix = TIE_COLOUR;
		add_job(j);
		add_job(random_item(OP_NONE));
		j = random_item(OP_BLEND);
		j.colour_a = IDX_W'(WHITE_IDX);
		j.colour_b = IDX_W'(WHITE_IDX);
		add_job(j);
		j.colour_a = IDX_W'(MIX_A);
		j.colour_b = IDX_W'(MIX_B);
		add_job(j);
		queue_drain();

		// one blend per mode from BM_SUBSAT up, unused modes included; two per fade mode
		for (int m = BM_SUBSAT; m <= MODE_LAST; m++) begin
			queue_cfg(REG_BLEND_MODE, WGT_W'(m));
			j = random_item(OP_BLEND);
			j.colour_a = IDX_W'(MIX_A);
			j.colour_b = IDX_W'(MIX_B);
			case (m)
				BM_SUBSAT: begin
					j.colour_a = IDX_W'(BLACK_IDX);
					j.colour_b = IDX_W'(WHITE_IDX);
				end
				BM_INC:                j.colour_a = IDX_W'(WHITE_IDX);
				BM_DEC:                j.colour_a = IDX_W'(BLACK_IDX);
				BM_FADEOUT, BM_FADEIN: j.amount = '0;
				default: ;
			endcase
			add_job(j);
			if (m == BM_FADEOUT || m == BM_FADEIN) begin
				j.amount = '1;
				add_job(j);
			end
		end

		// random phases, each with its own mode and freshly written weights
		for (int k = 0; k < BLOCKS; k++) begin
			fill_gap = k < 4 ? 23 : (k < 8 ? 66 : 0);
			mode_word = WGT_W'($urandom);
			mode_word[3:0] = 4'(k);
			w_red = WGT_W'($urandom);
			w_green = WGT_W'($urandom);
			w_blue = WGT_W'($urandom);
			case (k % 4)
				1: begin
					w_red = '0;
					w_green = WEIGHT_MAX;
				end
				2: begin
					w_red = WEIGHT_MAX;
					w_green = WEIGHT_MAX;
					w_blue = WEIGHT_MAX;
				end
				3: begin
					w_green = '0;
					w_blue = k == 3 ? '0 : WEIGHT_MAX;
					if (k == 3)
						w_red = '0;
				end
				default: ;
			endcase
			queue_cfg(REG_BLEND_MODE, mode_word);
			queue_cfg(REG_WEIGHT_RED, w_red);
			queue_cfg(REG_WEIGHT_GREEN, w_green);
			queue_cfg(REG_WEIGHT_BLUE, w_blue);
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				if (n == BLOCK_ITEMS / 2 || $urandom_range(99) < 3)
					queue_drain();
				r = $urandom_range(99);
				if (r < 12)
					j = random_item(OP_WRITE);
				else if (r < 52)
					j = random_item(OP_BLEND);
				else if (r < 95)
					j = random_item(OP_QUANT);
				else
					j = random_item(OP_NONE);
				add_job(j);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_jobs.size() != 0 || start || cfg_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d palette writes, %0d blends over %0d modes, %0d quantize queries",
			n_writes, n_blends, $countones(modes_seen), n_quants);
		$display("%0d register writes, %0d results checked, %0d failures",
			n_regs, n_checked, fail_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
